// ===== rtl/tlpt_pkg.sv =====
package tlpt_pkg;

   localparam int DIR_AW    = 10;
   localparam int TBL_AW    = 10;
   localparam int DIR_DEPTH = 1024;

   localparam logic [31:0] F_PRESENT = 32'h0000_0001;
   localparam logic [31:0] F_RW      = 32'h0000_0002;
   localparam logic [31:0] F_LARGE   = 32'h0000_0080;
   localparam logic [31:0] MASK_4K   = 32'hFFFF_F000;
   localparam logic [31:0] MASK_4M   = 32'hFFC0_0000;

   typedef enum logic [2:0] {
      FN_MAP4K  = 3'd0,
      FN_MAP4M  = 3'd1,
      FN_UNMAP  = 3'd2,
      FN_LOOKUP = 3'd3,
      FN_SET    = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      STAT_DONE     = 2'd0,
      STAT_ABSENT   = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_CONFLICT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_DIR,
      S_TBL
   } state_type;

   typedef enum logic [1:0] {
      ESEL_ZERO,
      ESEL_DIR,
      ESEL_POOL
   } esel_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] virt_addr;
      logic [31:0] phys_addr;
      logic [11:0] pte_flags;
      logic [31:0] new_entry;
   } req_type;

   typedef struct packed {
      logic [31:0] entry_out;
      logic [1:0]  status;
   } rsp_type;

endpackage

// ===== rtl/tlpt_req_if.sv =====
interface tlpt_req_if import tlpt_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tlpt_rsp_if.sv =====
interface tlpt_rsp_if import tlpt_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/two_level_page_table_store.sv =====
// channel   dir   fields                                             accepted when
// req_ch    in    func, virt_addr, phys_addr, pte_flags, new_entry   valid && ready
// rsp_ch    out   entry_out, status                                  valid && ready
//
// an item passes a directory read, then the dependent table read
// through the single read port of the table pool, with the write-back at the end
// a stalled rsp_ch holds the item in the table stage until the output register frees
// after reset a clearing pass over every table pool word loads both memories,
// with req_ch.ready low throughout
// one item is at work at a time; the next is taken as the current one leaves
module two_level_page_table_store import tlpt_pkg::*; #(
   parameter int TABLE_POOL = 16
) (
   input logic       clock,
   input logic       reset,
   tlpt_req_if.sink   req_ch,
   tlpt_rsp_if.source rsp_ch
);

   localparam int POOL_DEPTH = TABLE_POOL * DIR_DEPTH;
   localparam int PA_W       = $clog2(POOL_DEPTH);
   localparam int TIX_W      = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
   localparam int UW         = $clog2(TABLE_POOL + 1);

   logic [31:0] dir_mem [DIR_DEPTH];
   logic [31:0] pool_mem [POOL_DEPTH];

   state_type   state_ff, state_in;
   logic [PA_W-1:0] clr_ff, clr_in;
   logic [UW-1:0]   used_ff, used_in;
   req_type     req_ff;
   logic [31:0] dir_rd_ff;
   logic [31:0] pool_rd_ff;
   logic [PA_W-1:0] slot_ff, slot_in;
   logic        pwr_ff, pwr_in;
   logic [31:0] pwdata_ff, pwdata_in;
   status_type  stat_ff, stat_in;
   esel_type    esel_ff, esel_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;

   logic req_accept, tbl_done, out_free, clear_last, clr_in_dir;
   logic [DIR_AW-1:0] di;
   logic [TBL_AW-1:0] ti;
   logic present, big_page, has_tbl, full;
   logic [PA_W-1:0] tbl_slot, new_slot;
   logic [31:0] map4k_word;
   logic        dir_we;
   logic [DIR_AW-1:0] dir_waddr;
   logic [31:0] dir_wdata;
   logic        pool_we, pool_re;
   logic [PA_W-1:0] pool_waddr;
   logic [31:0] pool_wdata;
   logic [31:0] entry_sel;

   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign tbl_done   = (state_ff == S_TBL) && out_free;
   assign req_ch.ready = (state_ff == S_IDLE) || tbl_done;
   assign req_accept = req_ch.valid && req_ch.ready;
   assign clear_last = (clr_ff == PA_W'(POOL_DEPTH - 1));
   assign clr_in_dir = ((clr_ff >> DIR_AW) == '0);

   assign di = req_ff.virt_addr[31:22];
   assign ti = req_ff.virt_addr[21:12];

   assign present  = dir_rd_ff[0];
   assign big_page = present && dir_rd_ff[7];
   assign has_tbl  = present && !dir_rd_ff[7] && (dir_rd_ff[31:12] < 20'(used_ff));
   assign full     = (used_ff == UW'(TABLE_POOL));
   assign tbl_slot = PA_W'({dir_rd_ff[12 +: TIX_W], ti});
   assign new_slot = PA_W'({TIX_W'(used_ff), ti});
   assign map4k_word = (req_ff.phys_addr & MASK_4K) | {20'b0, req_ff.pte_flags} | F_PRESENT;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clear_last) state_in = S_IDLE;
         S_IDLE:  if (req_accept) state_in = S_DIR;
         S_DIR:   state_in = S_TBL;
         S_TBL: begin
            if (req_accept) state_in = S_DIR;
            else if (tbl_done) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // decode and memory control
   always_comb begin
      clr_in    = clr_ff;
      used_in   = used_ff;
      slot_in   = slot_ff;
      pwr_in    = pwr_ff;
      pwdata_in = pwdata_ff;
      stat_in   = stat_ff;
      esel_in   = esel_ff;
      dir_we    = 1'b0;
      dir_waddr = di;
      dir_wdata = '0;
      pool_re   = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in    = clr_ff + PA_W'(1);
            dir_we    = clr_in_dir;
            dir_waddr = clr_ff[DIR_AW-1:0];
            dir_wdata = (clr_ff == '0) ? (F_PRESENT | F_RW) : F_RW;
         end
         S_DIR: begin
            pool_re   = 1'b1;
            slot_in   = tbl_slot;
            pwr_in    = 1'b0;
            pwdata_in = '0;
            esel_in   = ESEL_ZERO;
            stat_in   = STAT_ABSENT;
            unique case (req_ff.func)
               FN_MAP4K: begin
                  priority if (big_page) begin
                     stat_in = STAT_CONFLICT;
                  end else if (has_tbl) begin
                     pwr_in    = 1'b1;
                     pwdata_in = map4k_word;
                     stat_in   = STAT_DONE;
                  end else if (present) begin
                     stat_in = STAT_ABSENT;
                  end else if (full) begin
                     stat_in = STAT_FULL;
                  end else begin
                     dir_we    = 1'b1;
                     dir_wdata = {20'(used_ff),
                                  (req_ff.pte_flags & ~F_LARGE[11:0]) | F_PRESENT[11:0]};
                     used_in   = used_ff + UW'(1);
                     slot_in   = new_slot;
                     pwr_in    = 1'b1;
                     pwdata_in = map4k_word;
                     stat_in   = STAT_DONE;
                  end
               end
               FN_MAP4M: begin
                  dir_we    = 1'b1;
                  dir_wdata = (req_ff.phys_addr & MASK_4M) | {20'b0, req_ff.pte_flags}
                              | F_PRESENT | F_LARGE;
                  stat_in   = STAT_DONE;
               end
               FN_UNMAP: begin
                  if (big_page) begin
                     dir_we    = 1'b1;
                     dir_wdata = F_RW;
                     stat_in   = STAT_DONE;
                  end else if (has_tbl) begin
                     pwr_in  = 1'b1;
                     stat_in = STAT_DONE;
                  end
               end
               FN_LOOKUP: begin
                  if (big_page) begin
                     esel_in = ESEL_DIR;
                     stat_in = STAT_DONE;
                  end else if (has_tbl) begin
                     esel_in = ESEL_POOL;
                     stat_in = STAT_DONE;
                  end
               end
               FN_SET: begin
                  if (big_page) begin
                     dir_we    = 1'b1;
                     dir_wdata = req_ff.new_entry;
                     stat_in   = STAT_DONE;
                  end else if (has_tbl) begin
                     pwr_in    = 1'b1;
                     pwdata_in = req_ff.new_entry;
                     stat_in   = STAT_DONE;
                  end
               end
               default: stat_in = STAT_ABSENT;
            endcase
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      pool_we    = (state_ff == S_CLEAR) || (tbl_done && pwr_ff);
      pool_waddr = (state_ff == S_CLEAR) ? clr_ff : slot_ff;
      if (state_ff == S_CLEAR) begin
         pool_wdata = clr_in_dir ? {10'b0, clr_ff[DIR_AW-1:0], 12'h003} : '0;
      end else begin
         pool_wdata = pwdata_ff;
      end
   end

   always_comb begin
      unique case (esel_ff)
         ESEL_DIR:  entry_sel = dir_rd_ff;
         ESEL_POOL: entry_sel = pool_rd_ff;
         default:   entry_sel = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (tbl_done) rsp_valid_in = 1'b1;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // memories
   always_ff @(posedge clock) begin
      if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
      if (req_accept) dir_rd_ff <= dir_mem[req_ch.data.virt_addr[31:22]];
   end

   always_ff @(posedge clock) begin
      if (pool_we) pool_mem[pool_waddr] <= pool_wdata;
      if (pool_re) pool_rd_ff <= pool_mem[tbl_slot];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         used_ff      <= UW'(1);
         rsp_valid_ff <= 1'b0;
         pwr_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         pwr_ff       <= pwr_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_accept) req_ff <= req_ch.data;
      slot_ff   <= slot_in;
      pwdata_ff <= pwdata_in;
      stat_ff   <= stat_in;
      esel_ff   <= esel_in;
      if (tbl_done) begin
         rsp_data_ff.entry_out <= entry_sel;
         rsp_data_ff.status    <= stat_ff;
      end
   end

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ch.ready)
      else $error("item taken during clearing pass");

   a_used_grows_on_map: assert property (@(posedge clock) disable iff (reset)
      (used_ff != $past(used_ff)) |->
         ($past(state_ff) == S_DIR && $past(req_ff.func) == FN_MAP4K))
      else $error("table taken outside a 4 KB map");

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      (used_ff != '0) && (used_ff <= UW'(TABLE_POOL)))
      else $error("table count out of range");

   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      tbl_done |=> rsp_valid_ff && (state_ff == S_IDLE || state_ff == S_DIR))
      else $error("finished item not presented");

   a_item_pool_write: assert property (@(posedge clock) disable iff (reset)
      (pool_we && state_ff != S_CLEAR) |-> (pwr_ff && state_ff == S_TBL))
      else $error("stray table pool write");

endmodule
